// ----- hdl/mecanum_wheel_speed_solver_assert.svh -----
// Assertion macros shared by the checker files of the wheel speed solver.
// No dependencies; the including module must have clk and rst in scope.
`ifndef MECANUM_WHEEL_SPEED_SOLVER_ASSERT_SVH
`define MECANUM_WHEEL_SPEED_SOLVER_ASSERT_SVH

// Checked only outside reset.
`define MWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked during reset as well.
`define MWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mws_pkg.sv -----
// Shared types and constants of the mecanum wheel speed solver.
// No dependencies.
package mws_pkg;

  localparam int FIELD_W    = 18;
  localparam int NUM_WHEELS = 4;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = NUM_WHEELS * FIELD_W;

  localparam logic signed [FIELD_W-1:0] RATIO_RESET = 18'sd52429;

  typedef enum logic [1:0] {
    RATIO_LF = 2'd0,
    RATIO_LB = 2'd1,
    RATIO_RB = 2'd2,
    RATIO_RF = 2'd3
  } ratio_idx_t;

endpackage

// ----- hdl/mws_sqrt_pipe.sv -----
// Pipelined integer square root, one root bit per register stage.
// No dependencies; a tag and a valid bit travel alongside the operand.
module mws_sqrt_pipe #(
  parameter int RB = 18,
  parameter int TW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  logic [2*RB-1:0] rad,
  input  logic [TW-1:0]   tag_in,
  output logic            vld_out,
  output logic [RB-1:0]   root,
  output logic [TW-1:0]   tag_out
);

  logic [RB:0]     rem_q  [RB];
  logic [RB-1:0]   root_q [RB];
  logic [2*RB-1:0] rad_q  [RB];
  logic [TW-1:0]   tag_q  [RB];
  logic [RB-1:0]   vld_q;

  for (genvar i = 0; i < RB; i++) begin : g_stage
    logic [RB:0]     rem_i;
    logic [RB-1:0]   root_i;
    logic [2*RB-1:0] rad_i;
    logic [TW-1:0]   tag_i;
    logic            vld_i;
    logic [RB+2:0]   rem_t;
    logic [RB+2:0]   trial;
    logic            geq;

    if (i == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
      assign tag_i  = tag_in;
      assign vld_i  = vld_in;
    end else begin : g_next
      assign rem_i  = rem_q[i-1];
      assign root_i = root_q[i-1];
      assign rad_i  = rad_q[i-1];
      assign tag_i  = tag_q[i-1];
      assign vld_i  = vld_q[i-1];
    end

    always_comb begin
      rem_t = {rem_i, rad_i[2*(RB-1-i)+1 -: 2]};
      trial = {1'b0, root_i, 2'b01};
      geq   = rem_t >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= geq ? (RB+1)'(rem_t - trial) : (RB+1)'(rem_t);
        root_q[i] <= {root_i[RB-2:0], geq};
        rad_q[i]  <= rad_i;
        tag_q[i]  <= tag_i;
      end
    end
  end

  assign vld_out = vld_q[RB-1];
  assign root    = root_q[RB-1];
  assign tag_out = tag_q[RB-1];

endmodule

// ----- hdl/mws_div_pipe.sv -----
// Pipelined restoring divider: several numerators over one shared divisor,
// one quotient bit per register stage. No dependencies.
module mws_div_pipe #(
  parameter int NW    = 35,
  parameter int DW    = 18,
  parameter int QW    = 17,
  parameter int LANES = 2,
  parameter int TW    = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_in,
  input  logic [LANES-1:0][NW-1:0]   num,
  input  logic [DW-1:0]              den,
  input  logic [TW-1:0]              tag_in,
  output logic                       vld_out,
  output logic [LANES-1:0][QW-1:0]   quo,
  output logic [TW-1:0]              tag_out
);

  logic [LANES-1:0][DW-1:0] rem_q [QW];
  logic [LANES-1:0][QW-1:0] low_q [QW];
  logic [LANES-1:0][QW-1:0] quo_q [QW];
  logic [DW-1:0]            den_q [QW];
  logic [TW-1:0]            tag_q [QW];
  logic [QW-1:0]            vld_q;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [LANES-1:0][DW-1:0] rem_i;
    logic [LANES-1:0][QW-1:0] low_i;
    logic [LANES-1:0][QW-1:0] quo_i;
    logic [DW-1:0]            den_i;
    logic [TW-1:0]            tag_i;
    logic                     vld_i;
    logic [LANES-1:0][DW:0]   trial;
    logic [LANES-1:0]         geq;

    if (i == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_i[l] = DW'(num[l] >> QW);
          low_i[l] = num[l][QW-1:0];
          quo_i[l] = '0;
        end
      end
      assign den_i = den;
      assign tag_i = tag_in;
      assign vld_i = vld_in;
    end else begin : g_next
      assign rem_i = rem_q[i-1];
      assign low_i = low_q[i-1];
      assign quo_i = quo_q[i-1];
      assign den_i = den_q[i-1];
      assign tag_i = tag_q[i-1];
      assign vld_i = vld_q[i-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_i[l], low_i[l][QW-1-i]};
        geq[l]   = trial[l] >= {1'b0, den_i};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[i][l] <= geq[l] ? DW'(trial[l] - {1'b0, den_i}) : DW'(trial[l]);
          quo_q[i][l] <= {quo_i[l][QW-2:0], geq[l]};
        end
        low_q[i] <= low_i;
        den_q[i] <= den_i;
        tag_q[i] <= tag_i;
      end
    end
  end

  assign vld_out = vld_q[QW-1];
  assign quo     = quo_q[QW-1];
  assign tag_out = tag_q[QW-1];

endmodule

// ----- hdl/mecanum_wheel_speed_solver.sv -----
// Top level of the mecanum wheel speed solver: clamp, unit scaling, mixing
// and wheel normalization. Uses mws_pkg, mws_sqrt_pipe and mws_div_pipe.
//
//   channel  direction  handshake          contents
//   s_*      in         tvalid/tready      chassis command beat
//   m_*      out        tvalid/tready      four wheel speeds
//   cfg_*    in         cfg_we             spin ratio register write
//
// One command enters per cycle while the output beat is not held. The pipeline
// is made of an 18-stage square root pipe, two dividers of FRAC_BITS + 1 stages
// each and nine single register stages. Reset clears all valid bits and loads
// the ratios with 0.8. When the output beat is held, every stage holds with it.
module mecanum_wheel_speed_solver #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // forward_vel [17:0], side_vel [35:18], spin_rate [53:36], zero [55:54]
  input  logic [mws_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // speed_lf [17:0], speed_lb [35:18], speed_rb [53:36], speed_rf [71:54]
  output logic [mws_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [mws_pkg::FIELD_W-1:0]    cfg_data
);

  localparam int F    = FRAC_BITS;
  localparam int FW   = mws_pkg::FIELD_W;
  localparam int NWH  = mws_pkg::NUM_WHEELS;
  localparam int CW   = (F + 2 > FW) ? F + 2 : FW;
  localparam int L2W  = (2 * F + 2 > 2 * FW) ? 2 * F + 2 : 2 * FW;
  localparam int RB   = L2W / 2;
  localparam int PW   = 2 * FW;
  localparam int TMW  = PW + 1 - F;
  localparam int QW   = F + 1;
  localparam int XUW  = (F + 1 > FW) ? F + 1 : FW;
  localparam int SPW  = ((XUW > TMW) ? XUW : TMW) + 3;
  localparam int NW1  = FW + F + 1;
  localparam int NW2  = SPW + F + 1;
  localparam int T1W  = 3 + 2 * FW + NWH * TMW;
  localparam int T2W  = 1 + NWH + NWH * FW;

  localparam logic signed [CW-1:0] ONE_C     = CW'(64'sd1 << F);
  localparam logic signed [CW-1:0] NEG_ONE_C = -ONE_C;
  localparam logic [L2W-1:0]       ONE_SQ    = L2W'(1) << (2 * F);
  localparam logic [PW:0]          HALF      = (PW + 1)'(1) << (F - 1);
  localparam logic [SPW-1:0]       ONE_S     = SPW'(1) << F;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Spin ratio registers
  logic signed [FW-1:0] ratio [NWH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NWH; i++) begin
        ratio[i] <= mws_pkg::RATIO_RESET;
      end
    end else if (cfg_we) begin
      case (mws_pkg::ratio_idx_t'(cfg_index))
        mws_pkg::RATIO_LF: ratio[0] <= cfg_data;
        mws_pkg::RATIO_LB: ratio[1] <= cfg_data;
        mws_pkg::RATIO_RB: ratio[2] <= cfg_data;
        mws_pkg::RATIO_RF: ratio[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: clamp
  logic signed [FW-1:0] in_x, in_y, in_s;
  logic signed [CW-1:0] ext_x, ext_y;
  logic signed [FW-1:0] clamp_x, clamp_y;
  logic                 a_vld;
  logic signed [FW-1:0] a_x, a_y, a_s;

  always_comb begin
    in_x  = $signed(s_tdata[FW-1:0]);
    in_y  = $signed(s_tdata[2*FW-1:FW]);
    in_s  = $signed(s_tdata[3*FW-1:2*FW]);
    ext_x = CW'(in_x);
    ext_y = CW'(in_y);
    if (ext_x > ONE_C) begin
      clamp_x = FW'(ONE_C);
    end else if (ext_x < NEG_ONE_C) begin
      clamp_x = FW'(NEG_ONE_C);
    end else begin
      clamp_x = in_x;
    end
    if (ext_y > ONE_C) begin
      clamp_y = FW'(ONE_C);
    end else if (ext_y < NEG_ONE_C) begin
      clamp_y = FW'(NEG_ONE_C);
    end else begin
      clamp_y = in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x <= clamp_x;
      a_y <= clamp_y;
      a_s <= in_s;
    end
  end

  // Stage B: magnitudes, squares, spin products
  logic [FW-1:0]        mag_ax, mag_ay;
  logic                 b_vld, b_negx, b_negy;
  logic [FW-1:0]        b_magx, b_magy;
  logic [PW-1:0]        b_sqx, b_sqy;
  logic signed [PW-1:0] b_prod [NWH];

  assign mag_ax = a_x[FW-1] ? FW'(-a_x) : FW'(a_x);
  assign mag_ay = a_y[FW-1] ? FW'(-a_y) : FW'(a_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_negx <= a_x[FW-1];
      b_negy <= a_y[FW-1];
      b_magx <= mag_ax;
      b_magy <= mag_ay;
      b_sqx  <= mag_ax * mag_ax;
      b_sqy  <= mag_ay * mag_ay;
      for (int i = 0; i < NWH; i++) begin
        b_prod[i] <= a_s * ratio[i];
      end
    end
  end

  // Stage C: length test, rounded spin terms
  logic [PW-1:0]         pmag [NWH];
  logic [PW:0]           psum [NWH];
  logic [TMW-1:0]        tq   [NWH];
  logic [L2W-1:0]        len2;
  logic                  c_vld, c_big, c_negx, c_negy;
  logic [FW-1:0]         c_magx, c_magy;
  logic [L2W-1:0]        c_len2;
  logic [NWH-1:0][TMW-1:0] c_term;

  always_comb begin
    len2 = L2W'(b_sqx) + L2W'(b_sqy);
    for (int i = 0; i < NWH; i++) begin
      pmag[i] = b_prod[i][PW-1] ? PW'(-b_prod[i]) : PW'(b_prod[i]);
      psum[i] = (PW + 1)'(pmag[i]) + HALF;
      tq[i]   = psum[i][PW:F];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_big  <= len2 > ONE_SQ;
      c_negx <= b_negx;
      c_negy <= b_negy;
      c_magx <= b_magx;
      c_magy <= b_magy;
      c_len2 <= len2;
      for (int i = 0; i < NWH; i++) begin
        c_term[i] <= b_prod[i][PW-1] ? TMW'(-tq[i]) : tq[i];
      end
    end
  end

  // Square root of the vector length
  logic           r_vld;
  logic [RB-1:0]  r_root;
  logic [T1W-1:0] r_tag;
  logic [FW-1:0]  r_magx, r_magy;

  mws_sqrt_pipe #(
    .RB (RB),
    .TW (T1W)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (c_vld),
    .rad     (c_len2),
    .tag_in  ({c_big, c_negx, c_negy, c_magx, c_magy, c_term}),
    .vld_out (r_vld),
    .root    (r_root),
    .tag_out (r_tag)
  );

  assign r_magy = r_tag[NWH*TMW +: FW];
  assign r_magx = r_tag[NWH*TMW+FW +: FW];

  // Stage P: unit scaling numerators
  logic                     p_vld;
  logic [1:0][NW1-1:0]      p_num;
  logic [RB-1:0]            p_den;
  logic [T1W-1:0]           p_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num[0] <= (NW1'(r_magx) << F) + NW1'(r_root >> 1);
      p_num[1] <= (NW1'(r_magy) << F) + NW1'(r_root >> 1);
      p_den    <= r_root;
      p_tag    <= r_tag;
    end
  end

  logic                 u_vld;
  logic [1:0][QW-1:0]   u_quo;
  logic [T1W-1:0]       u_tag;
  logic                 u_big, u_negx, u_negy;
  logic [FW-1:0]        u_magx, u_magy;
  logic [NWH-1:0][TMW-1:0] u_term;

  mws_div_pipe #(
    .NW    (NW1),
    .DW    (RB),
    .QW    (QW),
    .LANES (2),
    .TW    (T1W)
  ) u_unit_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (p_vld),
    .num     (p_num),
    .den     (p_den),
    .tag_in  (p_tag),
    .vld_out (u_vld),
    .quo     (u_quo),
    .tag_out (u_tag)
  );

  assign {u_big, u_negx, u_negy, u_magx, u_magy, u_term} = u_tag;

  // Stage D: wheel mixing
  logic [XUW-1:0]        ux, uy;
  logic signed [SPW-1:0] xs, ys;
  logic signed [SPW-1:0] ts [NWH];
  logic                  d_vld;
  logic signed [SPW-1:0] d_sp [NWH];

  always_comb begin
    ux = u_big ? XUW'(u_quo[0]) : XUW'(u_magx);
    uy = u_big ? XUW'(u_quo[1]) : XUW'(u_magy);
    xs = u_negx ? -$signed(SPW'(ux)) : $signed(SPW'(ux));
    ys = u_negy ? -$signed(SPW'(uy)) : $signed(SPW'(uy));
    for (int i = 0; i < NWH; i++) begin
      ts[i] = SPW'($signed(u_term[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= u_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_sp[0] <= xs - ys - ts[0];
      d_sp[1] <= xs + ys - ts[1];
      d_sp[2] <= xs - ys + ts[2];
      d_sp[3] <= xs + ys + ts[3];
    end
  end

  // Stage E: wheel magnitudes
  logic                       e_vld;
  logic [SPW-1:0]             e_mag [NWH];
  logic [NWH-1:0]             e_neg;
  logic [NWH-1:0][FW-1:0]     e_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NWH; i++) begin
        e_mag[i] <= d_sp[i][SPW-1] ? SPW'(-d_sp[i]) : SPW'(d_sp[i]);
        e_neg[i] <= d_sp[i][SPW-1];
        e_lo[i]  <= d_sp[i][FW-1:0];
      end
    end
  end

  // Stage F: largest magnitude
  logic [SPW-1:0]         max01, max23, max_all;
  logic                   f_vld, f_big;
  logic [SPW-1:0]         f_mx;
  logic [SPW-1:0]         f_mag [NWH];
  logic [NWH-1:0]         f_neg;
  logic [NWH-1:0][FW-1:0] f_lo;

  always_comb begin
    max01   = (e_mag[0] > e_mag[1]) ? e_mag[0] : e_mag[1];
    max23   = (e_mag[2] > e_mag[3]) ? e_mag[2] : e_mag[3];
    max_all = (max01 > max23) ? max01 : max23;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_mx  <= max_all;
      f_big <= max_all > ONE_S;
      f_mag <= e_mag;
      f_neg <= e_neg;
      f_lo  <= e_lo;
    end
  end

  // Stage G: wheel scaling numerators
  logic                     g_vld;
  logic [NWH-1:0][NW2-1:0]  g_num;
  logic [SPW-1:0]           g_den;
  logic [T2W-1:0]           g_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (en) begin
      g_vld <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NWH; i++) begin
        g_num[i] <= (NW2'(f_mag[i]) << F) + NW2'(f_mx >> 1);
      end
      g_den <= f_mx;
      g_tag <= {f_big, f_neg, f_lo};
    end
  end

  logic                     w_vld;
  logic [NWH-1:0][QW-1:0]   w_quo;
  logic [T2W-1:0]           w_tag;
  logic                     w_big;
  logic [NWH-1:0]           w_neg;
  logic [NWH-1:0][FW-1:0]   w_lo;
  logic [NWH-1:0][FW-1:0]   w_scaled;

  mws_div_pipe #(
    .NW    (NW2),
    .DW    (SPW),
    .QW    (QW),
    .LANES (NWH),
    .TW    (T2W)
  ) u_wheel_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (g_vld),
    .num     (g_num),
    .den     (g_den),
    .tag_in  (g_tag),
    .vld_out (w_vld),
    .quo     (w_quo),
    .tag_out (w_tag)
  );

  assign {w_big, w_neg, w_lo} = w_tag;

  always_comb begin
    for (int i = 0; i < NWH; i++) begin
      w_scaled[i] = w_neg[i] ? FW'(-FW'(w_quo[i])) : FW'(w_quo[i]);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= w_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= w_big ? w_scaled : w_lo;
    end
  end

endmodule

// ----- hdl/mws_checker.sv -----
// Port-level checker for the mecanum wheel speed solver, bound to the top.
// Uses mws_pkg and the assertion macros header.
`include "mecanum_wheel_speed_solver_assert.svh"

module mws_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [mws_pkg::OUT_DATA_W-1:0] m_tdata
);

  // The pipeline moves as a whole, so input readiness follows the output side.
  `MWS_ASSERT(a_ready_follows_out, s_tready == (!m_tvalid || m_tready), "s_tready mismatch")

  `MWS_ASSERT(a_out_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "beat dropped")

  `MWS_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> !m_tvalid, "m_tvalid after reset")

endmodule

bind mecanum_wheel_speed_solver mws_checker u_mws_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- dv/mecanum_wheel_speed_solver_tb.sv -----
// Self-checking testbench for the mecanum wheel speed solver: directed
// corner commands, then random ones under several spin ratio settings.
// Depends on mws_pkg and mecanum_wheel_speed_solver.
module mecanum_wheel_speed_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam longint ONE = 64'sd1 <<< FRAC_BITS;
  localparam int DRAIN_CYCLES = 120;

  typedef logic signed [mws_pkg::FIELD_W-1:0] fld_t;
  typedef struct packed {
    fld_t rf;
    fld_t rb;
    fld_t lb;
    fld_t lf;
  } wheels_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [mws_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [mws_pkg::OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [mws_pkg::FIELD_W-1:0] cfg_data = '0;

  wheels_t expected_speeds[$];
  longint spin_ratio[mws_pkg::NUM_WHEELS];
  int mismatches = 0;
  bit steady = 0;

  mecanum_wheel_speed_solver #(.FRAC_BITS(FRAC_BITS)) uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint scaled_round(longint v, longint d);
    longint q;
    q = ((v < 0 ? -v : v) * ONE + d / 2) / d;
    return v < 0 ? -q : q;
  endfunction

  function automatic longint spin_share(longint s, longint r);
    longint p;
    longint q;
    p = s * r;
    q = ((p < 0 ? -p : p) + (ONE >>> 1)) >>> FRAC_BITS;
    return p < 0 ? -q : q;
  endfunction

  function automatic wheels_t solve_wheels(fld_t fx, fld_t fy, fld_t fs);
    longint x, y, m, mx;
    longint sp[mws_pkg::NUM_WHEELS];
    wheels_t w;
    x = fx;
    y = fy;
    if (x > ONE) x = ONE;
    if (x < -ONE) x = -ONE;
    if (y > ONE) y = ONE;
    if (y < -ONE) y = -ONE;
    if (x * x + y * y > ONE * ONE) begin
      m = longint'(isqrt64(longint'(x * x + y * y)));
      x = scaled_round(x, m);
      y = scaled_round(y, m);
    end
    sp[0] = x - y - spin_share(fs, spin_ratio[mws_pkg::RATIO_LF]);
    sp[1] = x + y - spin_share(fs, spin_ratio[mws_pkg::RATIO_LB]);
    sp[2] = x - y + spin_share(fs, spin_ratio[mws_pkg::RATIO_RB]);
    sp[3] = x + y + spin_share(fs, spin_ratio[mws_pkg::RATIO_RF]);
    mx = ONE;
    foreach (sp[i]) if ((sp[i] < 0 ? -sp[i] : sp[i]) > mx) mx = sp[i] < 0 ? -sp[i] : sp[i];
    if (mx > ONE) foreach (sp[i]) sp[i] = scaled_round(sp[i], mx);
    w.lf = sp[0][mws_pkg::FIELD_W-1:0];
    w.lb = sp[1][mws_pkg::FIELD_W-1:0];
    w.rb = sp[2][mws_pkg::FIELD_W-1:0];
    w.rf = sp[3][mws_pkg::FIELD_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    wheels_t got, exp_w;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_speeds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", m_tdata);
      end else begin
        exp_w = expected_speeds.pop_front();
        if (got !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch lf/lb/rb/rf expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                     exp_w.lf, exp_w.lb, exp_w.rb, exp_w.rf,
                     got.lf, got.lb, got.rb, got.rf);
        end
      end
    end
    m_tready <= steady || $urandom_range(99) >= 35;
  end

  task automatic send_cmd(fld_t fx, fld_t fy, fld_t fs);
    while (!steady && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, fs, fy, fx};
    do @(posedge clk); while (!s_tready);
    expected_speeds.push_back(solve_wheels(fx, fy, fs));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_speeds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_ratios(fld_t lf, fld_t lb, fld_t rb, fld_t rf);
    fld_t vals[mws_pkg::NUM_WHEELS];
    vals = '{lf, lb, rb, rf};
    wait_idle();
    for (int i = 0; i < mws_pkg::NUM_WHEELS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= mws_pkg::ratio_idx_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      spin_ratio[i] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic fld_t rand_vel();
    case ($urandom_range(3))
      0: return fld_t'($urandom);
      1: return fld_t'($signed($urandom_range(32'(2 * ONE))) - ONE);
      2: return fld_t'($signed($urandom_range(400)) - 200);
      default: return $urandom_range(1) ? fld_t'(ONE) : fld_t'(-ONE);
    endcase
  endfunction

  task automatic test_directed();
    fld_t maxv, minv;
    maxv = 18'sh1FFFF;
    minv = -18'sh20000;
    send_cmd(0, 0, 0);
    send_cmd(maxv, 0, 0);
    send_cmd(minv, 0, 0);
    send_cmd(0, maxv, 0);
    send_cmd(0, minv, 0);
    send_cmd(0, 0, maxv);
    send_cmd(0, 0, minv);
    send_cmd(maxv, maxv, maxv);
    send_cmd(minv, minv, minv);
    send_cmd(maxv, minv, 0);
    send_cmd(fld_t'(ONE), fld_t'(ONE), 0);
    send_cmd(fld_t'(-ONE), fld_t'(ONE), fld_t'(ONE));
    send_cmd(0, fld_t'(ONE), 0);
    send_cmd(0, fld_t'(-ONE), fld_t'(ONE));
    send_cmd(-40000, 60000, 0);
    send_cmd(-65535, -3, -1);
    send_cmd(30000, 20000, 1000);
    send_cmd(1, -1, 1);
    send_cmd(46341, 46341, 0);
    send_cmd(-46340, 46341, 32768);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_cmd(rand_vel(), rand_vel(), $urandom_range(3) == 0 ? rand_vel() : fld_t'($urandom));
  endtask

  task automatic test_steady_stream(int n);
    steady = 1;
    test_random(n);
    steady = 0;
  endtask

  initial begin
    foreach (spin_ratio[i]) spin_ratio[i] = mws_pkg::RATIO_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_steady_stream(200);
    set_ratios(65536, 65536, 65536, 65536);
    test_directed();
    test_random(250);
    set_ratios(-65536, -65536, -65536, -65536);
    test_random(250);
    set_ratios(18'sh1FFFF, -18'sh20000, 0, 1);
    test_directed();
    test_random(250);
    set_ratios(fld_t'($urandom), fld_t'($urandom), fld_t'($urandom), fld_t'($urandom));
    test_random(250);
    set_ratios(0, 0, 0, 0);
    test_random(150);
    set_ratios(mws_pkg::RATIO_RESET, mws_pkg::RATIO_RESET, mws_pkg::RATIO_RESET,
               mws_pkg::RATIO_RESET);
    test_random(150);
    wait_idle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
